>>> rtl/rgba_alpha_blend_pixel_assert.svh
// Assertion macros for the pixel blend pipeline.
// Included by the top level; no other dependencies.
`ifndef RGBA_ALPHA_BLEND_PIXEL_ASSERT_SVH
`define RGBA_ALPHA_BLEND_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define RGBAB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbab assertion failed");
`define RGBAB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbab assertion failed");
`else
`define RGBAB_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RGBAB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rgbab_pkg.sv
// Shared types, register codes and byte helpers for the pixel blend pipeline.
// No dependencies.
package rgbab_pkg;

   typedef logic [1:0] byte_pos_type;
   typedef logic [7:0] chan_map_type;
   typedef logic [2:0] csr_index_type;

   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
      logic load4;
   } stage_en_type;

   localparam csr_index_type CSR_SRC_MAP       = 3'd0;
   localparam csr_index_type CSR_SRC_HAS_ALPHA = 3'd1;
   localparam csr_index_type CSR_DST_MAP       = 3'd2;
   localparam csr_index_type CSR_DST_HAS_ALPHA = 3'd3;
   localparam csr_index_type CSR_BLEND_ENABLE  = 3'd4;

   localparam chan_map_type MAP_RESET    = 8'd228;
   localparam logic [7:0]   ALPHA_OPAQUE = 8'd255;

   function automatic logic [7:0] pick_byte(input logic [31:0] word, input byte_pos_type pos);
      logic [31:0] sh;
      sh = word >> {pos, 3'b000};
      return sh[7:0];
   endfunction

   function automatic logic [31:0] place_byte(input logic [7:0] value, input byte_pos_type pos);
      return {24'd0, value} << {pos, 3'b000};
   endfunction

endpackage

>>> rtl/rgbab_unpack.sv
// Stage 1: picks colour and alpha bytes out of the source and backdrop words.
// Depends on rgbab_pkg.
module rgbab_unpack (
   input  logic                  clock,
   input  rgbab_pkg::stage_en_type en,
   input  rgbab_pkg::chan_map_type src_map,
   input  logic                  src_has_alpha,
   input  rgbab_pkg::chan_map_type dst_map,
   input  logic [31:0]           source_word,
   input  logic [31:0]           backdrop_word,
   output logic [7:0]            alpha,
   output logic [7:0]            src_r,
   output logic [7:0]            src_g,
   output logic [7:0]            src_b,
   output logic [7:0]            dst_r,
   output logic [7:0]            dst_g,
   output logic [7:0]            dst_b,
   output logic [31:0]           src_word
);
   import rgbab_pkg::*;

   logic [7:0]  alpha_ff, alpha_in;
   logic [7:0]  src_r_ff, src_g_ff, src_b_ff;
   logic [7:0]  dst_r_ff, dst_g_ff, dst_b_ff;
   logic [31:0] src_word_ff;

   assign alpha_in = src_has_alpha ? pick_byte(source_word, src_map[7:6]) : ALPHA_OPAQUE;

   always_ff @(posedge clock) begin
      if (en.load1) begin
         alpha_ff    <= alpha_in;
         src_r_ff    <= pick_byte(source_word, src_map[1:0]);
         src_g_ff    <= pick_byte(source_word, src_map[3:2]);
         src_b_ff    <= pick_byte(source_word, src_map[5:4]);
         dst_r_ff    <= pick_byte(backdrop_word, dst_map[1:0]);
         dst_g_ff    <= pick_byte(backdrop_word, dst_map[3:2]);
         dst_b_ff    <= pick_byte(backdrop_word, dst_map[5:4]);
         src_word_ff <= source_word;
      end
   end

   assign alpha    = alpha_ff;
   assign src_r    = src_r_ff;
   assign src_g    = src_g_ff;
   assign src_b    = src_b_ff;
   assign dst_r    = dst_r_ff;
   assign dst_g    = dst_g_ff;
   assign dst_b    = dst_b_ff;
   assign src_word = src_word_ff;

endmodule

>>> rtl/rgbab_mix_lane.sv
// Stages 2 and 3 of one colour lane: weighted sum, then exact divide by 255.
// Depends on rgbab_pkg.
module rgbab_mix_lane (
   input  logic                    clock,
   input  rgbab_pkg::stage_en_type en,
   input  logic [7:0]              alpha,
   input  logic [7:0]              src_c,
   input  logic [7:0]              dst_c,
   output logic [7:0]              mixed
);
   import rgbab_pkg::*;

   logic [15:0] sum_ff, sum_in;
   logic [7:0]  mixed_ff;
   logic [15:0] prod_s, prod_d;
   logic [15:0] div_acc;
   logic [7:0]  inv_alpha;

   assign inv_alpha = ALPHA_OPAQUE - alpha;
   assign prod_s    = {8'd0, alpha} * {8'd0, src_c};
   assign prod_d    = {8'd0, inv_alpha} * {8'd0, dst_c};
   assign sum_in    = prod_s + prod_d;

   // x/255 == (x + 1 + (x >> 8)) >> 8 for x below 65535
   assign div_acc = sum_ff + 16'd1 + {8'd0, sum_ff[15:8]};

   always_ff @(posedge clock) begin
      if (en.load2) begin
         sum_ff <= sum_in;
      end
      if (en.load3) begin
         mixed_ff <= div_acc[15:8];
      end
   end

   assign mixed = mixed_ff;

endmodule

>>> rtl/rgba_alpha_blend_pixel.sv
// Top level of the RGBA8888 "over" blend pipeline: config registers, stall
// control, repacking and output register. Depends on rgbab_pkg, rgbab_unpack,
// rgbab_mix_lane and rgba_alpha_blend_pixel_assert.svh.
//
// Four-stage pipeline: unpack, multiply-add, divide by 255, repack. A word is
// accepted every cycle while rsp_ready is high; a stall on the result side holds
// every full stage in place, while empty stages still take words. Configuration
// is applied live and must only be written when idle.
module rgba_alpha_blend_pixel (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_source_word,
   input  logic [31:0]              req_backdrop_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_blended_word,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  rgbab_pkg::csr_index_type csr_index,
   input  logic [7:0]               csr_wdata
);
   import rgbab_pkg::*;
`include "rgba_alpha_blend_pixel_assert.svh"

   chan_map_type src_map_ff, dst_map_ff;
   logic         src_alpha_ff, dst_alpha_ff, blend_en_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic take1, take2, take3, take4;
   stage_en_type en;

   logic [7:0]  a1, sr1, sg1, sb1, dr1, dg1, db1;
   logic [31:0] src1;
   logic [7:0]  a2_ff, a3_ff;
   logic [31:0] src2_ff, src3_ff;
   logic [7:0]  r3, g3, b3;
   logic [31:0] packed_word;
   logic [31:0] word_ff, word_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_map_ff   <= MAP_RESET;
         src_alpha_ff <= 1'b1;
         dst_map_ff   <= MAP_RESET;
         dst_alpha_ff <= 1'b1;
         blend_en_ff  <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_MAP:       src_map_ff   <= csr_wdata;
            CSR_SRC_HAS_ALPHA: src_alpha_ff <= csr_wdata[0];
            CSR_DST_MAP:       dst_map_ff   <= csr_wdata;
            CSR_DST_HAS_ALPHA: dst_alpha_ff <= csr_wdata[0];
            CSR_BLEND_ENABLE:  blend_en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stall chain: a stage takes a new word when empty or when it moves on
   assign take4 = !v4_ff || rsp_ready;
   assign take3 = !v3_ff || take4;
   assign take2 = !v2_ff || take3;
   assign take1 = !v1_ff || take2;

   assign en.load1 = take1;
   assign en.load2 = take2;
   assign en.load3 = take3;
   assign en.load4 = take4;

   assign req_ready = take1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= req_valid;
         if (take2) v2_ff <= v1_ff;
         if (take3) v3_ff <= v2_ff;
         if (take4) v4_ff <= v3_ff;
      end
   end

   rgbab_unpack u_unpack (
      .clock         (clock),
      .en            (en),
      .src_map       (src_map_ff),
      .src_has_alpha (src_alpha_ff),
      .dst_map       (dst_map_ff),
      .source_word   (req_source_word),
      .backdrop_word (req_backdrop_word),
      .alpha         (a1),
      .src_r         (sr1),
      .src_g         (sg1),
      .src_b         (sb1),
      .dst_r         (dr1),
      .dst_g         (dg1),
      .dst_b         (db1),
      .src_word      (src1)
   );

   rgbab_mix_lane u_lane_r (
      .clock (clock), .en (en), .alpha (a1), .src_c (sr1), .dst_c (dr1), .mixed (r3)
   );
   rgbab_mix_lane u_lane_g (
      .clock (clock), .en (en), .alpha (a1), .src_c (sg1), .dst_c (dg1), .mixed (g3)
   );
   rgbab_mix_lane u_lane_b (
      .clock (clock), .en (en), .alpha (a1), .src_c (sb1), .dst_c (db1), .mixed (b3)
   );

   always_ff @(posedge clock) begin
      if (take2) begin
         a2_ff   <= a1;
         src2_ff <= src1;
      end
      if (take3) begin
         a3_ff   <= a2_ff;
         src3_ff <= src2_ff;
      end
   end

   assign packed_word = place_byte(b3, dst_map_ff[5:4])
                      | place_byte(r3, dst_map_ff[1:0])
                      | place_byte(g3, dst_map_ff[3:2])
                      | (dst_alpha_ff ? place_byte(a3_ff, dst_map_ff[7:6]) : 32'd0);

   assign word_in = blend_en_ff ? packed_word : src3_ff;

   always_ff @(posedge clock) begin
      if (en.load4) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_blended_word = word_ff;

   `RGBAB_ASSERT_IMPL(a_ready_only_when_full, clock, reset, !req_ready,
      v1_ff && v2_ff && v3_ff && v4_ff)
   `RGBAB_ASSERT_NEXT(a_stage3_reaches_out, clock, reset, v3_ff && take4, v4_ff)
   `RGBAB_ASSERT_NEXT(a_copy_passes_source, clock, reset, v3_ff && take4 && !blend_en_ff,
      rsp_blended_word == $past(src3_ff))

endmodule
